@@ rtl/mdp_pkg.sv @@
// shared types and constants for the microcoded datapath step block
`timescale 1ns / 1ps

package mdp_pkg;

  localparam int NumPtrs = 5;
  localparam logic [15:0] PtrStackReset = 16'hFEFF;
  localparam logic [7:0] ByteOnes = 8'hFF;

  // microcode word layout, msb first
  typedef struct packed {
    logic       bsel;
    logic       clrc;
    logic       setc;
    logic       shc;
    logic       ldzn;
    logic       hlt;
    logic       urst;
    logic [2:0] fsel;
    logic       ldf;
    logic       sh1;
    logic       sh0;
    logic       cinp;
    logic       m;
    logic [3:0] s;
    logic       dec;
    logic       inc;
    logic [2:0] ps;
    logic [3:0] dst;
    logic [3:0] src;
  } cw_t;

  typedef struct packed {
    logic v;
    logic n;
    logic z;
    logic c;
  } flags_t;

  typedef enum logic [3:0] {
    SRC_NONE    = 4'd0,
    SRC_ACC     = 4'd1,
    SRC_B       = 4'd2,
    SRC_T       = 4'd3,
    SRC_T2      = 4'd4,
    SRC_ALU     = 4'd5,
    SRC_FLAGS   = 4'd6,
    SRC_MEM     = 4'd7,
    SRC_ADDR_LO = 4'd8,
    SRC_ADDR_HI = 4'd9
  } bus_src_t;

  typedef enum logic [3:0] {
    DST_NONE    = 4'd0,
    DST_ACC     = 4'd1,
    DST_B       = 4'd2,
    DST_T       = 4'd3,
    DST_T2      = 4'd4,
    DST_FLAGS   = 4'd5,
    DST_IR      = 4'd6,
    DST_MEM     = 4'd7,
    DST_PTR_LO  = 4'd8,
    DST_PTR_HI  = 4'd9
  } bus_dst_t;

  typedef enum logic [2:0] {
    COND_ZERO = 3'd0,
    COND_ONE  = 3'd1,
    COND_C    = 3'd2,
    COND_Z    = 3'd3,
    COND_N    = 3'd4,
    COND_V    = 3'd5,
    COND_LT   = 3'd6,
    COND_LE   = 3'd7
  } cond_t;

  // alu, shifter and flag results for one word
  typedef struct packed {
    logic [7:0] result;
    flags_t     flags;
  } alu_out_t;

  // everything one item reports
  typedef struct packed {
    logic [15:0] mem_address;
    logic        mem_read;
    logic        mem_write;
    logic [7:0]  bus_value;
    logic [12:0] next_micro_address;
    logic [3:0]  flags_now;
    logic [7:0]  acc_value;
    logic        is_halted;
  } step_res_t;

endpackage

@@ rtl/mdp_alu.sv @@
// 74181-style alu with two-stage shifter and flag generation
`timescale 1ns / 1ps

module mdp_alu (
  input  logic [7:0]         a,
  input  logic [7:0]         b,
  input  logic [3:0]         s,
  input  logic               m,
  input  logic               cin_n,
  input  logic               sh_left,
  input  logic               sh_right,
  input  logic               sh_carry,
  input  logic               carry_in_flag,
  output mdp_pkg::alu_out_t  alu_out
);

  logic [7:0] nb;
  logic [7:0] x_term;
  logic [7:0] y_term;
  logic [8:0] sum;
  logic [7:0] f;
  logic       sin;
  logic [7:0] g;
  logic [7:0] r;
  logic       shout;
  logic       is_add;

  assign nb = ~b;

  // the 181 splits every function into an or-term plus an and-term
  always_comb begin
    case (s[1:0])
      2'b00:   x_term = a;
      2'b01:   x_term = a | b;
      2'b10:   x_term = a | nb;
      default: x_term = mdp_pkg::ByteOnes;
    endcase
    case (s[3:2])
      2'b00:   y_term = '0;
      2'b01:   y_term = a & nb;
      2'b10:   y_term = a & b;
      default: y_term = a;
    endcase
  end

  assign sum = {1'b0, x_term} + {1'b0, y_term} + {8'd0, ~cin_n};
  assign f   = m ? ~(x_term ^ y_term) : sum[7:0];

  assign sin   = sh_carry & carry_in_flag;
  assign g     = sh_left ? {f[6:0], sin} : f;
  assign r     = sh_right ? {sin, g[7:1]} : g;
  assign shout = sh_left ? f[7] : (sh_right ? f[0] : 1'b0);

  assign is_add = ~s[2];

  assign alu_out.result  = r;
  assign alu_out.flags.c = (sh_left | sh_right) ? shout : sum[8];
  assign alu_out.flags.z = (r == 8'd0);
  assign alu_out.flags.n = r[7];
  assign alu_out.flags.v = (a[7] ^ f[7]) & (a[7] ^ b[7] ^ is_add);

endmodule

@@ rtl/mdp_core.sv @@
// datapath registers, bus muxes and commit of one microcode word
`timescale 1ns / 1ps

module mdp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [31:0]        control_word,
  input  logic [7:0]         read_data,
  output mdp_pkg::step_res_t res
);

  localparam int PtrIdxW = $clog2(mdp_pkg::NumPtrs);

  logic [7:0]     acc_r, acc_nxt;
  logic [7:0]     b_r, b_nxt;
  logic [7:0]     t_r, t_nxt;
  logic [7:0]     t2_r, t2_nxt;
  logic [7:0]     ir_r, ir_nxt;
  logic [15:0]    ptr_r [mdp_pkg::NumPtrs];
  logic [15:0]    ptr_nxt [mdp_pkg::NumPtrs];
  logic [3:0]     step_r, step_nxt;
  mdp_pkg::flags_t flags_r, flags_nxt;
  logic [2:0]     csel_r, csel_nxt;
  logic           halt_r, halt_nxt;

  mdp_pkg::cw_t      cw;
  mdp_pkg::alu_out_t alu_out;
  mdp_pkg::bus_src_t src;
  mdp_pkg::bus_dst_t dst;
  mdp_pkg::flags_t   base_flags;
  logic              pvalid;
  logic [PtrIdxW-1:0] pidx;
  logic [15:0]       addr;
  logic [15:0]       ptr_load;
  logic [7:0]        bus;
  logic              cond;

  assign cw     = mdp_pkg::cw_t'(control_word);
  assign src    = mdp_pkg::bus_src_t'(cw.src);
  assign dst    = mdp_pkg::bus_dst_t'(cw.dst);
  assign pvalid = (cw.ps < 3'(mdp_pkg::NumPtrs));
  assign pidx   = cw.ps[PtrIdxW-1:0];
  assign addr   = pvalid ? ptr_r[pidx] : 16'd0;

  mdp_alu u_alu (
    .a             (acc_r),
    .b             (cw.bsel ? t_r : b_r),
    .s             (cw.s),
    .m             (cw.m),
    .cin_n         (cw.cinp),
    .sh_left       (cw.sh0),
    .sh_right      (cw.sh1),
    .sh_carry      (cw.shc),
    .carry_in_flag (flags_r.c),
    .alu_out       (alu_out)
  );

  always_comb begin
    case (src)
      mdp_pkg::SRC_ACC:     bus = acc_r;
      mdp_pkg::SRC_B:       bus = b_r;
      mdp_pkg::SRC_T:       bus = t_r;
      mdp_pkg::SRC_T2:      bus = t2_r;
      mdp_pkg::SRC_ALU:     bus = alu_out.result;
      mdp_pkg::SRC_FLAGS:   bus = {4'd0, flags_r};
      mdp_pkg::SRC_MEM:     bus = read_data;
      mdp_pkg::SRC_ADDR_LO: bus = addr[7:0];
      mdp_pkg::SRC_ADDR_HI: bus = addr[15:8];
      default:              bus = mdp_pkg::ByteOnes;
    endcase
  end

  always_comb begin
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    t_nxt     = t_r;
    t2_nxt    = t2_r;
    ir_nxt    = ir_r;
    ptr_nxt   = ptr_r;
    step_nxt  = step_r;
    flags_nxt = flags_r;
    csel_nxt  = csel_r;
    halt_nxt  = halt_r;
    base_flags = flags_r;
    ptr_load  = addr;

    case (dst)
      mdp_pkg::DST_ACC:    acc_nxt = bus;
      mdp_pkg::DST_B:      b_nxt = bus;
      mdp_pkg::DST_T:      t_nxt = bus;
      mdp_pkg::DST_T2:     t2_nxt = bus;
      mdp_pkg::DST_FLAGS:  base_flags = mdp_pkg::flags_t'(bus[3:0]);
      mdp_pkg::DST_IR:     ir_nxt = bus;
      mdp_pkg::DST_PTR_LO: ptr_load = {addr[15:8], bus};
      mdp_pkg::DST_PTR_HI: ptr_load = {bus, addr[7:0]};
      default:             ;
    endcase

    // increment and decrement together cancel
    if (cw.inc && !cw.dec) begin
      ptr_load = ptr_load + 16'd1;
    end else if (cw.dec && !cw.inc) begin
      ptr_load = ptr_load - 16'd1;
    end

    if (!halt_r) begin
      if (pvalid) begin
        ptr_nxt[pidx] = ptr_load;
      end
      if (cw.ldf) begin
        flags_nxt = alu_out.flags;
      end else if (cw.ldzn) begin
        flags_nxt = base_flags;
        flags_nxt.z = (bus == 8'd0);
        flags_nxt.n = bus[7];
      end else begin
        flags_nxt = base_flags;
      end
      if (cw.setc) flags_nxt.c = 1'b1;
      if (cw.clrc) flags_nxt.c = 1'b0;
      csel_nxt = cw.fsel;
      step_nxt = cw.urst ? 4'd0 : step_r + 4'd1;
      halt_nxt = halt_r | cw.hlt;
    end else begin
      acc_nxt = acc_r;
      b_nxt   = b_r;
      t_nxt   = t_r;
      t2_nxt  = t2_r;
      ir_nxt  = ir_r;
    end
  end

  // branch condition from committed flags and select
  always_comb begin
    case (mdp_pkg::cond_t'(csel_nxt))
      mdp_pkg::COND_ONE: cond = 1'b1;
      mdp_pkg::COND_C:   cond = flags_nxt.c;
      mdp_pkg::COND_Z:   cond = flags_nxt.z;
      mdp_pkg::COND_N:   cond = flags_nxt.n;
      mdp_pkg::COND_V:   cond = flags_nxt.v;
      mdp_pkg::COND_LT:  cond = flags_nxt.n ^ flags_nxt.v;
      mdp_pkg::COND_LE:  cond = (flags_nxt.n ^ flags_nxt.v) | flags_nxt.z;
      default:           cond = 1'b0;
    endcase
  end

  assign res.mem_address        = halt_r ? 16'd0 : addr;
  assign res.mem_read           = ~halt_r & (src == mdp_pkg::SRC_MEM);
  assign res.mem_write          = ~halt_r & (dst == mdp_pkg::DST_MEM);
  assign res.bus_value          = halt_r ? 8'd0 : bus;
  assign res.next_micro_address = {cond, step_nxt, ir_nxt};
  assign res.flags_now          = flags_nxt;
  assign res.acc_value          = acc_nxt;
  assign res.is_halted          = halt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      b_r     <= '0;
      t_r     <= '0;
      t2_r    <= '0;
      ir_r    <= '0;
      for (int i = 0; i < mdp_pkg::NumPtrs; i++) begin
        ptr_r[i] <= (i == 3) ? mdp_pkg::PtrStackReset : 16'd0;
      end
      step_r  <= '0;
      flags_r <= '0;
      csel_r  <= '0;
      halt_r  <= 1'b0;
    end else if (step_en) begin
      acc_r   <= acc_nxt;
      b_r     <= b_nxt;
      t_r     <= t_nxt;
      t2_r    <= t2_nxt;
      ir_r    <= ir_nxt;
      ptr_r   <= ptr_nxt;
      step_r  <= step_nxt;
      flags_r <= flags_nxt;
      csel_r  <= csel_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

@@ rtl/microcoded_datapath_step.sv @@
// top level: input register, datapath step and result register
`timescale 1ns / 1ps

// microcoded 8-bit datapath, one microcode word per item
//
// in channel: in_valid / in_ready carry in_control_word and in_read_data,
// the word to execute and the memory byte for a memory-source word.
// out channel: out_valid / out_ready carry the bus, memory strobes and
// address of that word plus the committed accumulator, flags, halt state
// and next micro address.
// path: an accepted item sits in the input register; once the output
// register is free or draining, the datapath state commits and its result
// lands in the output register, which raises out_valid.
// throughput: one item per cycle while out_ready holds; the single-pass
// alu/shifter/bus logic between input and output registers sets it.
// a full output register stalls the step; the input register still takes
// one more item, and in_ready drops only when both registers hold items
// and out_ready is low.
// reset (rst_n low, synchronous) clears both valid bits, the datapath
// registers and flags, and loads pointer three with 0xfeff.
// after a halt word every item returns the current state unchanged.

module microcoded_datapath_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_control_word,
  input  logic [7:0]  in_read_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_mem_address,
  output logic        out_mem_read,
  output logic        out_mem_write,
  output logic [7:0]  out_bus_value,
  output logic [12:0] out_next_micro_address,
  output logic [3:0]  out_flags_now,
  output logic [7:0]  out_acc_value,
  output logic        out_is_halted
);

  // input register
  logic        in_v_r, in_v_nxt;
  logic [31:0] cw_r;
  logic [7:0]  rd_r;

  // result register
  logic               out_v_r, out_v_nxt;
  mdp_pkg::step_res_t res_r;
  mdp_pkg::step_res_t res;

  logic take;
  logic advance;

  // execute when a word is held and the result slot is free or draining
  assign advance  = in_v_r & (~out_v_r | out_ready);
  assign in_ready = ~in_v_r | advance;
  assign take     = in_valid & in_ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  mdp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .control_word (cw_r),
    .read_data    (rd_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      cw_r <= in_control_word;
      rd_r <= in_read_data;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_v_r;
  assign out_mem_address        = res_r.mem_address;
  assign out_mem_read           = res_r.mem_read;
  assign out_mem_write          = res_r.mem_write;
  assign out_bus_value          = res_r.bus_value;
  assign out_next_micro_address = res_r.next_micro_address;
  assign out_flags_now          = res_r.flags_now;
  assign out_acc_value          = res_r.acc_value;
  assign out_is_halted          = res_r.is_halted;

endmodule

@@ dv/tb.sv @@
// testbench for the microcoded datapath step block: predictor, scoreboard and stimulus
`timescale 1ns / 1ps

module tb;

  // run limit: roughly 1200 items at worst-case gaps and stalls, taken several times over
  localparam int unsigned CycleLimit = 400000;
  localparam int LongHoldCycles = 60;

  // source and destination codes that select nothing
  localparam logic [3:0] SrcUnused = 4'hF;
  localparam logic [3:0] DstUnused = 4'hC;

  // pointer selects used by the directed words
  localparam logic [2:0] PtrFirst = 3'd0;
  localparam logic [2:0] PtrStack = 3'd3;
  localparam logic [2:0] PtrLast = 3'd4;
  localparam logic [2:0] PtrBeyond = 3'd7;

  // alu select codes, named after their logic-mode function
  typedef enum logic [3:0] {
    FN_NOT_A      = 4'd0,
    FN_NOR        = 4'd1,
    FN_NOTA_AND_B = 4'd2,
    FN_ZERO       = 4'd3,
    FN_NAND       = 4'd4,
    FN_NOT_B      = 4'd5,
    FN_XOR        = 4'd6,
    FN_A_AND_NOTB = 4'd7,
    FN_NOTA_OR_B  = 4'd8,
    FN_XNOR       = 4'd9,
    FN_PASS_B     = 4'd10,
    FN_AND        = 4'd11,
    FN_ONES       = 4'd12,
    FN_A_OR_NOTB  = 4'd13,
    FN_OR         = 4'd14,
    FN_PASS_A     = 4'd15
  } alu_fn_t;

  // predicts each step of the datapath and checks results in order
  class step_scoreboard;
    logic [7:0]  acc_q, b_q, t_q, t2_q, ir_q;
    logic [15:0] ptr_q [mdp_pkg::NumPtrs];
    logic [3:0]  step_q;
    mdp_pkg::flags_t    flags_q;
    logic [2:0]  cond_q;
    logic        halted_q;
    mdp_pkg::step_res_t expected_q [$];
    int          words_seen, results_seen, errors;

    function new();
      acc_q = '0;
      b_q = '0;
      t_q = '0;
      t2_q = '0;
      ir_q = '0;
      foreach (ptr_q[i]) ptr_q[i] = '0;
      ptr_q[PtrStack] = mdp_pkg::PtrStackReset;
      step_q = '0;
      flags_q = '0;
      cond_q = '0;
      halted_q = 1'b0;
      words_seen = 0;
      results_seen = 0;
      errors = 0;
    endfunction

    // {carry out, result}; the carry comes from the arithmetic path in both modes
    function logic [8:0] alu_eval(logic [7:0] a, logic [7:0] b, logic [3:0] s,
                                  logic m, logic cin_n);
      logic [8:0] a9, b9, nb9, t;
      logic [7:0] lg;
      a9 = {1'b0, a};
      b9 = {1'b0, b};
      nb9 = {1'b0, ~b};
      case (alu_fn_t'(s))
        FN_NOT_A:      t = a9;
        FN_NOR:        t = a9 | b9;
        FN_NOTA_AND_B: t = a9 | nb9;
        FN_ZERO:       t = 9'h0FF;
        FN_NAND:       t = a9 + (a9 & nb9);
        FN_NOT_B:      t = (a9 | b9) + (a9 & nb9);
        FN_XOR:        t = a9 + nb9;
        FN_A_AND_NOTB: t = (a9 & nb9) + 9'h0FF;
        FN_NOTA_OR_B:  t = a9 + (a9 & b9);
        FN_XNOR:       t = a9 + b9;
        FN_PASS_B:     t = (a9 | nb9) + (a9 & b9);
        FN_AND:        t = (a9 & b9) + 9'h0FF;
        FN_ONES:       t = a9 + a9;
        FN_A_OR_NOTB:  t = (a9 | b9) + a9;
        FN_OR:         t = (a9 | nb9) + a9;
        default:       t = a9 + 9'h0FF;
      endcase
      // carry-in pin is active low
      t = t + {8'h00, ~cin_n};
      if (!m) return t;
      case (alu_fn_t'(s))
        FN_NOT_A:      lg = ~a;
        FN_NOR:        lg = ~(a | b);
        FN_NOTA_AND_B: lg = ~a & b;
        FN_ZERO:       lg = 8'h00;
        FN_NAND:       lg = ~(a & b);
        FN_NOT_B:      lg = ~b;
        FN_XOR:        lg = a ^ b;
        FN_A_AND_NOTB: lg = a & ~b;
        FN_NOTA_OR_B:  lg = ~a | b;
        FN_XNOR:       lg = ~(a ^ b);
        FN_PASS_B:     lg = b;
        FN_AND:        lg = a & b;
        FN_ONES:       lg = mdp_pkg::ByteOnes;
        FN_A_OR_NOTB:  lg = a | ~b;
        FN_OR:         lg = a | b;
        default:       lg = a;
      endcase
      return {t[8], lg};
    endfunction

    function logic cond_now();
      case (mdp_pkg::cond_t'(cond_q))
        mdp_pkg::COND_ONE: return 1'b1;
        mdp_pkg::COND_C:   return flags_q.c;
        mdp_pkg::COND_Z:   return flags_q.z;
        mdp_pkg::COND_N:   return flags_q.n;
        mdp_pkg::COND_V:   return flags_q.v;
        mdp_pkg::COND_LT:  return flags_q.n ^ flags_q.v;
        mdp_pkg::COND_LE:  return (flags_q.n ^ flags_q.v) | flags_q.z;
        default:           return 1'b0;
      endcase
    endfunction

    // runs one accepted word through the model and queues what it reports
    function void note_word(mdp_pkg::cw_t cw, logic [7:0] rd);
      mdp_pkg::step_res_t r;
      logic [8:0] alu;
      logic [7:0] bop, f, g, sh, bus;
      logic [15:0] addr;
      logic       pvalid, sin, shout;
      mdp_pkg::flags_t nf;
      r = '0;
      words_seen++;
      if (!halted_q) begin
        pvalid = cw.ps < mdp_pkg::NumPtrs;
        bop = cw.bsel ? t_q : b_q;
        alu = alu_eval(acc_q, bop, cw.s, cw.m, cw.cinp);
        f = alu[7:0];
        // left first, then right, optionally rotating through carry
        sin = cw.shc & flags_q.c;
        g = cw.sh0 ? {f[6:0], sin} : f;
        sh = cw.sh1 ? {sin, g[7:1]} : g;
        shout = cw.sh0 ? f[7] : (cw.sh1 ? f[0] : 1'b0);
        nf.c = (cw.sh0 | cw.sh1) ? shout : alu[8];
        nf.z = (sh == 8'h00);
        nf.n = sh[7];
        // overflow by the sign bits, add when s[2] is clear
        nf.v = (acc_q[7] ^ f[7]) & (acc_q[7] ^ bop[7] ^ ~cw.s[2]);
        addr = pvalid ? ptr_q[cw.ps] : 16'h0000;

        case (mdp_pkg::bus_src_t'(cw.src))
          mdp_pkg::SRC_ACC:     bus = acc_q;
          mdp_pkg::SRC_B:       bus = b_q;
          mdp_pkg::SRC_T:       bus = t_q;
          mdp_pkg::SRC_T2:      bus = t2_q;
          mdp_pkg::SRC_ALU:     bus = sh;
          mdp_pkg::SRC_FLAGS:   bus = {4'h0, flags_q};
          mdp_pkg::SRC_MEM: begin
            bus = rd;
            r.mem_read = 1'b1;
          end
          mdp_pkg::SRC_ADDR_LO: bus = addr[7:0];
          mdp_pkg::SRC_ADDR_HI: bus = addr[15:8];
          default:              bus = mdp_pkg::ByteOnes;
        endcase

        case (mdp_pkg::bus_dst_t'(cw.dst))
          mdp_pkg::DST_ACC:    acc_q = bus;
          mdp_pkg::DST_B:      b_q = bus;
          mdp_pkg::DST_T:      t_q = bus;
          mdp_pkg::DST_T2:     t2_q = bus;
          mdp_pkg::DST_FLAGS:  flags_q = bus[3:0];
          mdp_pkg::DST_IR:     ir_q = bus;
          mdp_pkg::DST_MEM:    r.mem_write = 1'b1;
          mdp_pkg::DST_PTR_LO: if (pvalid) ptr_q[cw.ps][7:0] = bus;
          mdp_pkg::DST_PTR_HI: if (pvalid) ptr_q[cw.ps][15:8] = bus;
          default: ;
        endcase
        if (pvalid && cw.inc) ptr_q[cw.ps] = ptr_q[cw.ps] + 16'd1;
        if (pvalid && cw.dec) ptr_q[cw.ps] = ptr_q[cw.ps] - 16'd1;
        if (cw.ldf) begin
          flags_q = nf;
        end else if (cw.ldzn) begin
          flags_q.z = (bus == 8'h00);
          flags_q.n = bus[7];
        end
        if (cw.setc) flags_q.c = 1'b1;
        if (cw.clrc) flags_q.c = 1'b0;
        cond_q = cw.fsel;
        step_q = cw.urst ? 4'h0 : step_q + 4'h1;
        if (cw.hlt) halted_q = 1'b1;
        r.mem_address = addr;
        r.bus_value = bus;
      end
      r.next_micro_address = {cond_now(), step_q, ir_q};
      r.flags_now = flags_q;
      r.acc_value = acc_q;
      r.is_halted = halted_q;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_step(mdp_pkg::step_res_t got);
      mdp_pkg::step_res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("mem_address", want.mem_address, got.mem_address);
      compare_field("mem_read", want.mem_read, got.mem_read);
      compare_field("mem_write", want.mem_write, got.mem_write);
      compare_field("bus_value", want.bus_value, got.bus_value);
      compare_field("next_micro_address", want.next_micro_address, got.next_micro_address);
      compare_field("flags_now", want.flags_now, got.flags_now);
      compare_field("acc_value", want.acc_value, got.acc_value);
      compare_field("is_halted", want.is_halted, got.is_halted);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_control_word = '0;
  logic [7:0]  in_read_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_mem_address;
  logic        out_mem_read;
  logic        out_mem_write;
  logic [7:0]  out_bus_value;
  logic [12:0] out_next_micro_address;
  logic [3:0]  out_flags_now;
  logic [7:0]  out_acc_value;
  logic        out_is_halted;

  step_scoreboard sb = new();

  // idling knobs per phase, and a one-shot request for a long output stall
  bit sender_idle = 1'b0;
  bit receiver_idle = 1'b0;
  bit long_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  microcoded_datapath_step dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_control_word        (in_control_word),
    .in_read_data           (in_read_data),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_mem_address        (out_mem_address),
    .out_mem_read           (out_mem_read),
    .out_mem_write          (out_mem_write),
    .out_bus_value          (out_bus_value),
    .out_next_micro_address (out_next_micro_address),
    .out_flags_now          (out_flags_now),
    .out_acc_value          (out_acc_value),
    .out_is_halted          (out_is_halted)
  );

  always #2 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // offers one item, optionally after an idle gap, and returns once it is taken
  task automatic send_word(input mdp_pkg::cw_t w, input logic [7:0] rd);
    int gap;
    gap = sender_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_control_word <= w;
    in_read_data <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w, rd);
  endtask

  // drops valid and waits until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic mdp_pkg::cw_t word_of(mdp_pkg::bus_src_t src, mdp_pkg::bus_dst_t dst);
    mdp_pkg::cw_t w;
    w = '0;
    w.src = src;
    w.dst = dst;
    return w;
  endfunction

  // random word, never halting; part of them restricted to real sources,
  // destinations and pointers with rare step resets and carry forcing
  function automatic mdp_pkg::cw_t random_word();
    mdp_pkg::cw_t w;
    w = $urandom();
    if ($urandom_range(0, 9) < 4) begin
      w.src = 4'($urandom_range(mdp_pkg::SRC_ACC, mdp_pkg::SRC_ADDR_HI));
      w.dst = 4'($urandom_range(mdp_pkg::DST_ACC, mdp_pkg::DST_PTR_HI));
      w.ps = 3'($urandom_range(0, mdp_pkg::NumPtrs - 1));
      w.urst = ($urandom_range(0, 7) == 0);
      w.setc = ($urandom_range(0, 5) == 0);
      w.clrc = ($urandom_range(0, 5) == 0);
    end
    w.hlt = 1'b0;
    return w;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_word(random_word(), 8'($urandom_range(0, 255)));
  endtask

  // result side: per-item stall draw, plus the long hold when asked
  initial begin : result_side
    int hold_left;
    mdp_pkg::step_res_t got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.mem_address = out_mem_address;
        got.mem_read = out_mem_read;
        got.mem_write = out_mem_write;
        got.bus_value = out_bus_value;
        got.next_micro_address = out_next_micro_address;
        got.flags_now = out_flags_now;
        got.acc_value = out_acc_value;
        got.is_halted = out_is_halted;
        sb.check_step(got);
        hold_left = receiver_idle ? $urandom_range(0, 15) : 0;
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    mdp_pkg::cw_t w;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed corner cases with random idling on both sides
    sender_idle = 1'b1;
    receiver_idle = 1'b1;

    // fill registers from memory, z and n taken from the bus for the first two
    w = word_of(mdp_pkg::SRC_MEM, mdp_pkg::DST_ACC);
    w.ldzn = 1'b1;
    send_word(w, 8'h00);
    w = word_of(mdp_pkg::SRC_MEM, mdp_pkg::DST_B);
    w.ldzn = 1'b1;
    send_word(w, 8'h01);
    w = word_of(mdp_pkg::SRC_MEM, mdp_pkg::DST_T);
    send_word(w, 8'h80);
    w = word_of(mdp_pkg::SRC_MEM, mdp_pkg::DST_T2);
    send_word(w, 8'hFF);
    w = word_of(mdp_pkg::SRC_MEM, mdp_pkg::DST_ACC);
    send_word(w, 8'h7F);
    // 0x7f + 1 overflows into the sign bit
    w = word_of(mdp_pkg::SRC_ALU, mdp_pkg::DST_ACC);
    w.s = FN_XNOR;
    w.cinp = 1'b1;
    w.ldf = 1'b1;
    w.fsel = mdp_pkg::COND_V;
    send_word(w, 8'h00);
    // subtract t with the carry pin active: a + ~t + 1
    w = word_of(mdp_pkg::SRC_ALU, mdp_pkg::DST_ACC);
    w.s = FN_XOR;
    w.bsel = 1'b1;
    w.ldf = 1'b1;
    w.fsel = mdp_pkg::COND_LT;
    send_word(w, 8'h00);
    // logic xor with b into t2
    w = word_of(mdp_pkg::SRC_ALU, mdp_pkg::DST_T2);
    w.s = FN_XOR;
    w.m = 1'b1;
    w.ldf = 1'b1;
    w.fsel = mdp_pkg::COND_Z;
    send_word(w, 8'h00);
    // rotate left through carry
    w = word_of(mdp_pkg::SRC_ALU, mdp_pkg::DST_ACC);
    w.s = FN_PASS_A;
    w.m = 1'b1;
    w.sh0 = 1'b1;
    w.shc = 1'b1;
    w.ldf = 1'b1;
    send_word(w, 8'h00);
    // rotate right through carry, then force carry high
    w = word_of(mdp_pkg::SRC_ALU, mdp_pkg::DST_ACC);
    w.s = FN_PASS_A;
    w.m = 1'b1;
    w.sh1 = 1'b1;
    w.shc = 1'b1;
    w.ldf = 1'b1;
    w.setc = 1'b1;
    send_word(w, 8'h00);
    // both shifts in one word; the carry ends up in the top bit only
    w = word_of(mdp_pkg::SRC_ALU, mdp_pkg::DST_B);
    w.s = FN_ONES;
    w.m = 1'b1;
    w.sh0 = 1'b1;
    w.sh1 = 1'b1;
    w.shc = 1'b1;
    w.ldf = 1'b1;
    send_word(w, 8'h00);
    // alu flags win over a flag register write, clear c wins over set c
    w = word_of(mdp_pkg::SRC_ALU, mdp_pkg::DST_FLAGS);
    w.s = FN_ONES;
    w.m = 1'b1;
    w.ldf = 1'b1;
    w.setc = 1'b1;
    w.clrc = 1'b1;
    w.fsel = mdp_pkg::COND_C;
    send_word(w, 8'h00);
    // unused source drives all ones, unused destination writes nothing
    w = '0;
    w.src = SrcUnused;
    w.dst = DstUnused;
    w.ldzn = 1'b1;
    w.fsel = mdp_pkg::COND_N;
    send_word(w, 8'h00);
    w = word_of(mdp_pkg::SRC_FLAGS, mdp_pkg::DST_ACC);
    w.fsel = mdp_pkg::COND_LE;
    send_word(w, 8'h00);
    // pointer select past the last pointer: address zero, no pointer updates
    w = word_of(mdp_pkg::SRC_ADDR_LO, mdp_pkg::DST_PTR_LO);
    w.ps = PtrBeyond;
    w.inc = 1'b1;
    send_word(w, 8'h00);
    w = word_of(mdp_pkg::SRC_ACC, mdp_pkg::DST_PTR_HI);
    w.ps = PtrBeyond;
    w.dec = 1'b1;
    send_word(w, 8'h00);
    // stack pointer high byte; increment and decrement together cancel
    w = word_of(mdp_pkg::SRC_ADDR_HI, mdp_pkg::DST_B);
    w.ps = PtrStack;
    w.inc = 1'b1;
    w.dec = 1'b1;
    send_word(w, 8'h00);
    // pointer zero wraps down through 0xffff and back up
    w = word_of(mdp_pkg::SRC_ADDR_HI, mdp_pkg::DST_T);
    w.ps = PtrFirst;
    w.dec = 1'b1;
    send_word(w, 8'h00);
    w = word_of(mdp_pkg::SRC_ADDR_HI, mdp_pkg::DST_ACC);
    w.ps = PtrFirst;
    w.inc = 1'b1;
    send_word(w, 8'h00);
    // load the last pointer, then write memory through it
    w = word_of(mdp_pkg::SRC_MEM, mdp_pkg::DST_PTR_HI);
    w.ps = PtrLast;
    send_word(w, 8'hA5);
    w = word_of(mdp_pkg::SRC_ACC, mdp_pkg::DST_PTR_LO);
    w.ps = PtrLast;
    w.inc = 1'b1;
    send_word(w, 8'h00);
    w = word_of(mdp_pkg::SRC_T2, mdp_pkg::DST_MEM);
    w.ps = PtrLast;
    w.fsel = mdp_pkg::COND_ONE;
    send_word(w, 8'h00);
    // instruction register load with step counter reset
    w = word_of(mdp_pkg::SRC_MEM, mdp_pkg::DST_IR);
    w.urst = 1'b1;
    send_word(w, 8'hC3);

    // back to back on both sides
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    send_random(300);

    // random gaps on both sides
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    send_random(300);

    // long output stall while items keep coming, so the block fills and
    // stalls its input; then hold the input until everything has drained
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    long_hold_req = 1'b1;
    send_random(24);
    drain();

    // one side idling at a time
    sender_idle = 1'b1;
    send_random(250);
    sender_idle = 1'b0;
    receiver_idle = 1'b1;
    send_random(250);

    // halt, then words that must change nothing
    w = random_word();
    w.hlt = 1'b1;
    send_word(w, 8'($urandom_range(0, 255)));
    repeat (5) begin
      w = random_word();
      w.hlt = 1'($urandom_range(0, 1));
      send_word(w, 8'($urandom_range(0, 255)));
    end

    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d microcode words: corner cases, random words under mixed gaps",
             sb.words_seen);
    $display("and stalls, a long output stall, a drain pause and a final halt;");
    $display("%0d results, %0d mismatches", sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
